FILE: hw/rtl/postfix_expression_evaluator_top_macros.svh
// postfix_expression_evaluator_top_macros.svh: assertion macros for the evaluator rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define PEV_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pev assertion failed: invariant");
// antecedent implies consequent in the same cycle
`define PEV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pev assertion failed: implication");
// antecedent implies consequent in the next cycle
`define PEV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pev assertion failed: next-cycle implication");
`else
`define PEV_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PEV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PEV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/pev_pkg.sv
// pev_pkg: widths, default stack depth, character codes and status codes of the postfix evaluator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pev_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int TOKEN_W  = 8;
    localparam int STATUS_W = 3;

    // default stack size
    localparam int PEV_STACK_DEPTH = 8;

    // token characters
    localparam logic [TOKEN_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [TOKEN_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [TOKEN_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [TOKEN_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [TOKEN_W-1:0] CH_0     = 8'h30;
    localparam logic [TOKEN_W-1:0] CH_9     = 8'h39;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

endpackage

`default_nettype wire

FILE: hw/rtl/postfix_expression_evaluator_top.sv
// postfix_expression_evaluator_top: postfix calculator on a ram-based operand stack
// depends on pev_pkg and postfix_expression_evaluator_top_macros.svh
// a word runs exec, divide (/ only), then finish, which waits for a free output register
// in_stall holds off the next word until finish is done (32-step restoring divider)
// reset (rst_n, async, active low) empties the stack; stack ram contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "postfix_expression_evaluator_top_macros.svh"

module postfix_expression_evaluator_top
    import pev_pkg::*;
#(
    parameter int STACK_DEPTH = PEV_STACK_DEPTH
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [TOKEN_W-1:0]               token,
    input  wire logic                             last_token,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic signed [DATA_W-1:0]              top_value,
    output logic [STATUS_W-1:0]                   status,
    output logic [$clog2(STACK_DEPTH+1)-1:0]      depth,
    output logic                                  expression_done
);

    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int CW     = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W = $clog2(DATA_W);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]          state_reg,      state_next;
    logic [TOKEN_W-1:0]  tok_reg,        tok_next;
    logic                last_reg,       last_next;
    logic [CW-1:0]       count_reg,      count_next;
    logic [DATA_W-1:0]   top_reg,        top_next;
    logic [DATA_W-1:0]   res_reg,        res_next;
    logic [STATUS_W-1:0] stat_reg,       stat_next;
    logic                write_reg,      write_next;
    logic                push_reg,       push_next;
    logic [DATA_W-1:0]   quo_reg,        quo_next;
    logic [DATA_W-1:0]   rem_reg,        rem_next;
    logic [DATA_W-1:0]   mb_reg,         mb_next;
    logic                neg_reg,        neg_next;
    logic [ITER_W-1:0]   iter_reg,       iter_next;
    logic                out_valid_reg,  out_valid_next;
    logic [DATA_W-1:0]   out_top_reg,    out_top_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [CW-1:0]       out_depth_reg,  out_depth_next;
    logic                out_done_reg,   out_done_next;

    // stack memory
    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;

    logic                in_accept;
    logic                out_free;
    logic [CW-1:0]       cnt_m2;
    logic [CW-1:0]       cnt_p1;
    logic [CW-1:0]       cnt_m1;
    logic                is_digit;
    logic                is_op;
    logic [DATA_W-1:0]   opa;
    logic [DATA_W-1:0]   opb;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W:0]     rem_diff;
    logic [DATA_W-1:0]   quo_step;
    logic [DATA_W-1:0]   rem_step;
    logic [CW-1:0]       new_count;
    logic [DATA_W-1:0]   new_top;

    assign in_stall        = (state_reg != S_IDLE);
    assign in_accept       = in_valid && !in_stall;
    assign out_free        = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign top_value       = out_top_reg;
    assign status          = out_status_reg;
    assign depth           = out_depth_reg;
    assign expression_done = out_done_reg;

    assign cnt_m2 = count_reg - CW'(2);
    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_p1 = count_reg + CW'(1);

    // token classes and operands (deeper entry from ram, top from register)
    assign is_digit = (tok_reg >= CH_0) && (tok_reg <= CH_9);
    assign is_op    = (tok_reg == CH_PLUS) || (tok_reg == CH_MINUS) ||
                      (tok_reg == CH_MUL) || (tok_reg == CH_DIV);
    assign opa      = rd_data_reg;
    assign opb      = top_reg;

    // one restoring divide step on magnitudes
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, mb_reg};
    assign quo_step  = {quo_reg[DATA_W-2:0], ~rem_diff[DATA_W]};
    assign rem_step  = rem_diff[DATA_W] ? rem_shift[DATA_W-1:0] : rem_diff[DATA_W-1:0];

    // stack after a successful token
    always_comb
    begin
        new_count = count_reg;
        new_top   = top_reg;
        if (write_reg)
        begin
            new_top   = res_reg;
            new_count = push_reg ? cnt_p1 : cnt_m1;
        end
    end

    // ram write back, only when the result can be handed over
    assign mem_we    = (state_reg == S_FINISH) && out_free && write_reg;
    assign mem_waddr = push_reg ? count_reg[AW-1:0] : cnt_m2[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= res_reg;
        end
    end

    // read of the deeper operand, issued when the word is accepted
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_data_reg <= stack_mem[cnt_m2[AW-1:0]];
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        tok_next        = tok_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        res_next        = res_reg;
        stat_next       = stat_reg;
        write_next      = write_reg;
        push_next       = push_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        mb_next         = mb_reg;
        neg_next        = neg_reg;
        iter_next       = iter_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_top_next    = out_top_reg;
        out_status_next = out_status_reg;
        out_depth_next  = out_depth_reg;
        out_done_next   = out_done_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    tok_next   = token;
                    last_next  = last_token;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                stat_next  = ST_OK;
                write_next = 1'b0;
                push_next  = 1'b0;
                state_next = S_FINISH;
                if (is_digit)
                begin
                    if (count_reg >= CW'(STACK_DEPTH))
                    begin
                        stat_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        res_next   = DATA_W'(tok_reg - CH_0);
                        write_next = 1'b1;
                        push_next  = 1'b1;
                    end
                end
                else if (is_op)
                begin
                    if (count_reg < CW'(2))
                    begin
                        stat_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        case (tok_reg)
                            CH_PLUS:
                            begin
                                res_next   = opa + opb;
                                write_next = 1'b1;
                            end
                            CH_MINUS:
                            begin
                                res_next   = opa - opb;
                                write_next = 1'b1;
                            end
                            CH_MUL:
                            begin
                                res_next   = DATA_W'(opa * opb);
                                write_next = 1'b1;
                            end
                            default:
                            begin
                                // division
                                if (opb == '0)
                                begin
                                    stat_next = ST_DIVZERO;
                                end
                                else
                                begin
                                    quo_next   = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
                                    mb_next    = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;
                                    rem_next   = '0;
                                    neg_next   = opa[DATA_W-1] ^ opb[DATA_W-1];
                                    iter_next  = '0;
                                    state_next = S_DIV;
                                end
                            end
                        endcase
                    end
                end
                else
                begin
                    stat_next = ST_INVALID;
                end
            end

            S_DIV:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DATA_W - 1))
                begin
                    res_next   = neg_reg ? (DATA_W'(0) - quo_step) : quo_step;
                    write_next = 1'b1;
                    push_next  = 1'b0;
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_top_next    = (new_count != '0) ? new_top : '0;
                    out_status_next = stat_reg;
                    out_depth_next  = new_count;
                    out_done_next   = last_reg;
                    top_next        = new_top;
                    count_next      = last_reg ? '0 : new_count;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        tok_reg        <= tok_next;
        last_reg       <= last_next;
        top_reg        <= top_next;
        res_reg        <= res_next;
        stat_reg       <= stat_next;
        write_reg      <= write_next;
        push_reg       <= push_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        mb_reg         <= mb_next;
        neg_reg        <= neg_next;
        iter_reg       <= iter_next;
        out_top_reg    <= out_top_next;
        out_status_reg <= out_status_next;
        out_depth_reg  <= out_depth_next;
        out_done_reg   <= out_done_next;
    end

    // checks
    `PEV_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(STACK_DEPTH))
    `PEV_ASSERT_IMPLIES(a_div_nonzero, clk, rst_n, state_reg == S_DIV, mb_reg != '0)
    `PEV_ASSERT_IMPLIES(a_push_room, clk, rst_n, mem_we && push_reg, count_reg < CW'(STACK_DEPTH))
    `PEV_ASSERT_IMPLIES(a_pop_two, clk, rst_n, mem_we && !push_reg, count_reg >= CW'(2))
    `PEV_ASSERT_IMPLIES(a_empty_zero, clk, rst_n, out_valid_reg && out_depth_reg == '0, out_top_reg == '0)
    `PEV_ASSERT_NEXT(a_done_clears, clk, rst_n, (state_reg == S_FINISH) && out_free && last_reg, count_reg == '0)

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for the postfix evaluator, with a scoreboard that
// tracks the operand stack and checks top, status, depth and done per word
// depends on pev_pkg and postfix_expression_evaluator_top
`timescale 1ns / 1ps
`default_nettype none

module tb_top
    import pev_pkg::*;
;

    localparam int DEPTH_W    = $clog2(PEV_STACK_DEPTH + 1);
    localparam int GAP_MAX    = 14;
    localparam int RANDOM_WORDS = 1500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [DATA_W-1:0] top;
        logic [STATUS_W-1:0]      st;
        logic [DEPTH_W-1:0]       dep;
        logic                     done;
    } eval_result_t;

    // scoreboard: mirrors the operand stack and queues one expected word per token
    class eval_scoreboard;
        logic [DATA_W-1:0] stack_mem [PEV_STACK_DEPTH];
        int unsigned       count;
        eval_result_t      pending [$];
        int                errors;
        int                words_in;
        int                words_out;
        int                exprs_done;
        int                st_seen [5];

        function new();
            count = 0;
            errors = 0;
            words_in = 0;
            words_out = 0;
            exprs_done = 0;
            foreach (st_seen[i]) st_seen[i] = 0;
        endfunction

        task report_miss(string msg);
            errors++;
            if (errors <= 20)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        // evaluate one accepted token against the mirrored stack
        function void note_word(logic [TOKEN_W-1:0] tok, logic last);
            eval_result_t      r;
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            logic [DATA_W-1:0] ma;
            logic [DATA_W-1:0] mb;
            logic [DATA_W-1:0] q;
            r.st = ST_OK;
            q = '0;
            if (tok >= CH_0 && tok <= CH_9) begin
                if (count >= PEV_STACK_DEPTH)
                    r.st = ST_OVERFLOW;
                else begin
                    stack_mem[count] = DATA_W'(tok - CH_0);
                    count++;
                end
            end
            else if (tok == CH_PLUS || tok == CH_MINUS || tok == CH_MUL || tok == CH_DIV) begin
                if (count < 2)
                    r.st = ST_UNDERFLOW;
                else begin
                    a = stack_mem[count-2];
                    b = stack_mem[count-1];
                    case (tok)
                        CH_PLUS:  q = a + b;
                        CH_MINUS: q = a - b;
                        CH_MUL:   q = a * b;
                        default:
                        begin
                            // truncating divide on magnitudes, most negative / -1 wraps
                            if (b == '0)
                                r.st = ST_DIVZERO;
                            else begin
                                ma = a[DATA_W-1] ? -a : a;
                                mb = b[DATA_W-1] ? -b : b;
                                q = ma / mb;
                                if (a[DATA_W-1] != b[DATA_W-1])
                                    q = -q;
                            end
                        end
                    endcase
                    if (r.st == ST_OK) begin
                        count--;
                        stack_mem[count-1] = q;
                    end
                end
            end
            else
                r.st = ST_INVALID;

            r.top = (count > 0) ? stack_mem[count-1] : '0;
            r.dep = DEPTH_W'(count);
            r.done = last;
            if (last)
                count = 0;
            pending.push_back(r);
            words_in++;
            st_seen[r.st]++;
            if (last)
                exprs_done++;
        endfunction

        // compare one received word with the oldest expectation
        task check_word(logic signed [DATA_W-1:0] top, logic [STATUS_W-1:0] st,
                        logic [DEPTH_W-1:0] dep, logic done);
            eval_result_t e;
            words_out++;
            if (pending.size() == 0)
                report_miss("result word with nothing pending");
            else begin
                e = pending.pop_front();
                if (top !== e.top)
                    report_miss($sformatf("word %0d top_value %0d, want %0d",
                                          words_out, top, e.top));
                if (st !== e.st)
                    report_miss($sformatf("word %0d status %0d, want %0d",
                                          words_out, st, e.st));
                if (dep !== e.dep)
                    report_miss($sformatf("word %0d depth %0d, want %0d",
                                          words_out, dep, e.dep));
                if (done !== e.done)
                    report_miss($sformatf("word %0d expression_done %0b, want %0b",
                                          words_out, done, e.done));
            end
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [TOKEN_W-1:0]            token;
    logic                          last_token;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [DATA_W-1:0]      top_value;
    logic [STATUS_W-1:0]           status;
    logic [DEPTH_W-1:0]            depth;
    logic                          expression_done;

    eval_scoreboard sb = new();
    bit             hold_done = 1'b0;

    postfix_expression_evaluator_top #(
        .STACK_DEPTH(PEV_STACK_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .token(token),
        .last_token(last_token),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .top_value(top_value),
        .status(status),
        .depth(depth),
        .expression_done(expression_done)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // offer one token word, entered and left at a falling edge
    task send_word(logic [TOKEN_W-1:0] tok, logic last);
        int gap;
        gap = ((sb.words_in / 64) % 4 == 3) ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        token <= tok;
        last_token <= last;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_word(tok, last);
        @(negedge clk);
    endtask

    // send a string of characters, flagging the final one as last if asked
    task send_text(string s, logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], last_at_end && (i == s.len() - 1));
    endtask

    function logic [TOKEN_W-1:0] pick_op();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    // one random expression: mostly well formed, with some noise and broken tokens
    task send_expression();
        int                 len;
        int                 n;
        int                 d;
        int                 r;
        logic [TOKEN_W-1:0] tok;
        logic               last;
        len = $urandom_range(1, 24);
        n = 0;
        d = 0;
        last = 1'b0;
        while (!last) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                tok = TOKEN_W'($urandom_range(0, 255));
            else if (r < 6)
                tok = CH_0 + TOKEN_W'($urandom_range(0, 9));
            else if (r < 8)
                tok = pick_op();
            else if (d < 2 || (r < 55 && d < PEV_STACK_DEPTH))
                tok = CH_0 + TOKEN_W'($urandom_range(0, 9));
            else
                tok = pick_op();
            // rough depth tracking to steer the shape
            if (tok >= CH_0 && tok <= CH_9) begin
                if (d < PEV_STACK_DEPTH)
                    d++;
            end
            else if (tok == CH_PLUS || tok == CH_MINUS || tok == CH_MUL || tok == CH_DIV) begin
                if (d >= 2)
                    d--;
            end
            n++;
            last = (n >= len && d == 1) || (n >= len + 12) || ($urandom_range(0, 99) == 0);
            send_word(tok, last);
        end
    endtask

    // receiver: random stalls, one long hold-off, checks every accepted word
    initial
    begin
        int g;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!hold_done && sb.words_out >= 400) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else begin
                g = ((sb.words_out / 50) % 4 == 1) ? 0 : $urandom_range(0, GAP_MAX);
                if (g > 0) begin
                    out_stall <= 1'b1;
                    repeat (g) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_word(top_value, status, depth, expression_done);
        end
    end

    // reset, directed tokens, random expressions, drain and verdict
    initial
    begin
        bit paused;
        paused = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        token <= '0;
        last_token <= 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // operator on empty stack, invalid extremes
        send_word(CH_PLUS, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        // underflow with one entry, then divide by zero
        send_text("9*0/", 1'b0);
        // invalid last token still clears the stack
        send_word(8'h3A, 1'b1);
        // negative quotient truncates toward zero
        send_text("07-2/", 1'b1);
        // fill, overflow, multiply up to the most negative value, divide by -1
        send_text("888888889*******8*8*2*01-/", 1'b1);

        while (sb.words_in < RANDOM_WORDS) begin
            // sender waits for the block to drain completely once
            if (!paused && sb.words_in >= 900) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                while (sb.pending.size() > 0) @(posedge clk);
                @(negedge clk);
            end
            send_expression();
        end
        in_valid <= 1'b0;

        while (sb.pending.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d words in %0d expressions, %0d results checked",
                 sb.words_in, sb.exprs_done, sb.words_out);
        $display("status mix: ok %0d overflow %0d underflow %0d div0 %0d invalid %0d",
                 sb.st_seen[ST_OK], sb.st_seen[ST_OVERFLOW], sb.st_seen[ST_UNDERFLOW],
                 sb.st_seen[ST_DIVZERO], sb.st_seen[ST_INVALID]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: postfix_expression_evaluator_top.f
+incdir+hw/rtl
hw/rtl/pev_pkg.sv
hw/rtl/postfix_expression_evaluator_top.sv
tb/sv/tb_top.sv
